// ----- rtl/core/x86_immediate_alu_and_shifter_macros.svh -----
// Assertion macros for the immediate ALU and shifter.
`ifndef X86_IMMEDIATE_ALU_AND_SHIFTER_MACROS_SVH
`define X86_IMMEDIATE_ALU_AND_SHIFTER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition implies a consequence in the same cycle.
`define X86IA_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define X86IA_ASSERT_NXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define X86IA_ASSERT_IMP(label, clk, rst_n, cond, cons)
`define X86IA_ASSERT_NXT(label, clk, rst_n, cond, cons)

`endif

`endif

// ----- rtl/core/x86ia_pkg.sv -----
// Shared types and operation codes for the immediate ALU and shifter.
package x86ia_pkg;

    // Operation codes carried in the action field
    localparam logic [3:0] ACT_ADD     = 4'd0;
    localparam logic [3:0] ACT_OR      = 4'd1;
    localparam logic [3:0] ACT_ADC     = 4'd2;
    localparam logic [3:0] ACT_SBB     = 4'd3;
    localparam logic [3:0] ACT_AND     = 4'd4;
    localparam logic [3:0] ACT_SUB     = 4'd5;
    localparam logic [3:0] ACT_XOR     = 4'd6;
    localparam logic [3:0] ACT_CMP     = 4'd7;
    localparam logic [3:0] ACT_ROL     = 4'd8;
    localparam logic [3:0] ACT_ROR     = 4'd9;
    localparam logic [3:0] ACT_RCL     = 4'd10;
    localparam logic [3:0] ACT_RCR     = 4'd11;
    localparam logic [3:0] ACT_SHL     = 4'd12;
    localparam logic [3:0] ACT_SHR     = 4'd13;
    localparam logic [3:0] ACT_SAR     = 4'd14;
    localparam logic [3:0] ACT_INVALID = 4'd15;

    typedef struct packed {
        logic [3:0]  action;
        logic        wide;
        logic [15:0] dest_value;
        logic [15:0] source_value;
        logic        sign_extend_imm;
        logic [7:0]  shift_count;
    } t_alu_in;

    typedef struct packed {
        logic [15:0] result;
        logic        write_back;
        logic        carry_out;
        logic        overflow_out;
        logic        zero_out;
        logic        sign_out;
        logic        parity_out;
        logic        aux_carry_out;
        logic        invalid_op;
    } t_alu_out;

    typedef struct packed {
        logic cf;
        logic of;
        logic zf;
        logic sf;
        logic pf;
        logic af;
    } t_flags;

endpackage

// ----- rtl/core/x86ia_alu.sv -----
// Single-pass execute logic: group-1 immediate ALU and group-2 barrel shifter.
module x86ia_alu (
    input  x86ia_pkg::t_alu_in  i_item,
    input  x86ia_pkg::t_flags   i_flags,
    output x86ia_pkg::t_alu_out o_item,
    output x86ia_pkg::t_flags   o_flags
);
    import x86ia_pkg::*;

    // Count modulo 9 for the 9-bit rotate through carry
    function automatic logic [4:0] mod9(input logic [4:0] c);
        logic [4:0] m;
        if (c < 5'd9) begin
            m = c;
        end else if (c < 5'd18) begin
            m = c - 5'd9;
        end else if (c < 5'd27) begin
            m = c - 5'd18;
        end else begin
            m = c - 5'd27;
        end
        return m;
    endfunction

    logic [15:0] a;
    logic [15:0] b;
    logic [4:0]  cnt;
    logic        cin;
    logic [16:0] sum;
    logic [16:0] diff;
    logic [15:0] r;
    logic [4:0]  k9;
    logic [4:0]  k17;
    logic [15:0] rol8_t;
    logic [31:0] rol16_t;
    logic [15:0] ror8_t;
    logic [31:0] ror16_t;
    logic [17:0] rcl9_t;
    logic [33:0] rcl17_t;
    logic [17:0] rcr9_t;
    logic [33:0] rcr17_t;
    logic [39:0] shl8_t;
    logic [47:0] shl16_t;
    logic [8:0]  shr8_t;
    logic [16:0] shr16_t;
    logic [8:0]  sar8_t;
    logic [16:0] sar16_t;
    logic [8:0]  rc9;
    logic [16:0] rc17;
    logic        msb_r;
    logic        msb2_r;
    logic        msb_a;
    logic        use_szp;

    // Select operands by width and immediate form
    always_comb begin
        a   = i_item.wide ? i_item.dest_value : {8'h00, i_item.dest_value[7:0]};
        if (!i_item.wide) begin
            b = {8'h00, i_item.source_value[7:0]};
        end else if (i_item.sign_extend_imm) begin
            b = {{8{i_item.source_value[7]}}, i_item.source_value[7:0]};
        end else begin
            b = i_item.source_value;
        end
        cnt = i_item.shift_count[4:0];
        cin = ((i_item.action == ACT_ADC) || (i_item.action == ACT_SBB)) ? i_flags.cf : 1'b0;
        sum  = {1'b0, a} + {1'b0, b} + {16'h0000, cin};
        diff = {1'b0, a} - {1'b0, b} - {16'h0000, cin};
    end

    // Barrel shifter and rotators for both widths
    always_comb begin
        k9      = mod9(cnt);
        k17     = (cnt < 5'd17) ? cnt : cnt - 5'd17;
        rol8_t  = {a[7:0], a[7:0]} << cnt[2:0];
        rol16_t = {a, a} << cnt[3:0];
        ror8_t  = {a[7:0], a[7:0]} >> cnt[2:0];
        ror16_t = {a, a} >> cnt[3:0];
        rcl9_t  = {i_flags.cf, a[7:0], i_flags.cf, a[7:0]} << k9;
        rcl17_t = {i_flags.cf, a, i_flags.cf, a} << k17;
        rcr9_t  = {i_flags.cf, a[7:0], i_flags.cf, a[7:0]} >> k9;
        rcr17_t = {i_flags.cf, a, i_flags.cf, a} >> k17;
        shl8_t  = {32'h0, a[7:0]} << cnt;
        shl16_t = {32'h0, a} << cnt;
        shr8_t  = {a[7:0], 1'b0} >> cnt;
        shr16_t = {a, 1'b0} >> cnt;
        sar8_t  = $signed({a[7:0], 1'b0}) >>> cnt;
        sar16_t = $signed({a, 1'b0}) >>> cnt;
        rc9     = 9'h000;
        rc17    = 17'h00000;
        if (i_item.action == ACT_RCL) begin
            rc9  = rcl9_t[17:9];
            rc17 = rcl17_t[33:17];
        end else begin
            rc9  = rcr9_t[8:0];
            rc17 = rcr17_t[16:0];
        end
    end

    // Execute the operation and update the flags
    always_comb begin
        o_flags = i_flags;
        o_item  = '0;
        o_item.result = a;
        r       = a;
        use_szp = 1'b0;
        msb_a   = i_item.wide ? a[15] : a[7];
        msb_r   = 1'b0;
        msb2_r  = 1'b0;
        case (i_item.action)
            ACT_ADD, ACT_ADC: begin
                r          = i_item.wide ? sum[15:0] : {8'h00, sum[7:0]};
                o_flags.cf = i_item.wide ? sum[16] : sum[8];
                o_flags.of = i_item.wide ? (~(a[15] ^ b[15]) & (a[15] ^ r[15]))
                                         : (~(a[7] ^ b[7]) & (a[7] ^ r[7]));
                o_flags.af = a[4] ^ b[4] ^ r[4];
                use_szp    = 1'b1;
            end
            ACT_SBB, ACT_SUB, ACT_CMP: begin
                r          = i_item.wide ? diff[15:0] : {8'h00, diff[7:0]};
                o_flags.cf = diff[16];
                o_flags.of = i_item.wide ? ((a[15] ^ b[15]) & (a[15] ^ r[15]))
                                         : ((a[7] ^ b[7]) & (a[7] ^ r[7]));
                o_flags.af = a[4] ^ b[4] ^ r[4];
                use_szp    = 1'b1;
            end
            ACT_OR, ACT_AND, ACT_XOR: begin
                if (i_item.action == ACT_OR) begin
                    r = a | b;
                end else if (i_item.action == ACT_AND) begin
                    r = a & b;
                end else begin
                    r = a ^ b;
                end
                o_flags.cf = 1'b0;
                o_flags.of = 1'b0;
                o_flags.af = 1'b0;
                use_szp    = 1'b1;
            end
            ACT_ROL: begin
                if (cnt != 5'd0) begin
                    r          = i_item.wide ? rol16_t[31:16] : {8'h00, rol8_t[15:8]};
                    o_flags.cf = r[0];
                    if (cnt == 5'd1) begin
                        o_flags.of = r[0] ^ (i_item.wide ? r[15] : r[7]);
                    end
                end
            end
            ACT_ROR: begin
                if (cnt != 5'd0) begin
                    r          = i_item.wide ? ror16_t[15:0] : {8'h00, ror8_t[7:0]};
                    msb_r      = i_item.wide ? r[15] : r[7];
                    msb2_r     = i_item.wide ? r[14] : r[6];
                    o_flags.cf = msb_r;
                    if (cnt == 5'd1) begin
                        o_flags.of = msb_r ^ msb2_r;
                    end
                end
            end
            ACT_RCL, ACT_RCR: begin
                if (cnt != 5'd0) begin
                    r          = i_item.wide ? rc17[15:0] : {8'h00, rc9[7:0]};
                    o_flags.cf = i_item.wide ? rc17[16] : rc9[8];
                    msb_r      = i_item.wide ? r[15] : r[7];
                    msb2_r     = i_item.wide ? r[14] : r[6];
                    if (i_item.action == ACT_RCL) begin
                        o_flags.of = o_flags.cf ^ msb_r;
                    end else begin
                        o_flags.of = msb_r ^ msb2_r;
                    end
                end
            end
            ACT_SHL: begin
                if (cnt != 5'd0) begin
                    r          = i_item.wide ? shl16_t[15:0] : {8'h00, shl8_t[7:0]};
                    o_flags.cf = i_item.wide ? shl16_t[16] : shl8_t[8];
                    msb_r      = i_item.wide ? r[15] : r[7];
                    o_flags.of = (cnt == 5'd1) ? (o_flags.cf ^ msb_r) : 1'b0;
                    o_flags.af = 1'b0;
                    use_szp    = 1'b1;
                end
            end
            ACT_SHR: begin
                if (cnt != 5'd0) begin
                    r          = i_item.wide ? shr16_t[16:1] : {8'h00, shr8_t[8:1]};
                    o_flags.cf = i_item.wide ? shr16_t[0] : shr8_t[0];
                    o_flags.of = (cnt == 5'd1) ? msb_a : 1'b0;
                    o_flags.af = 1'b0;
                    use_szp    = 1'b1;
                end
            end
            ACT_SAR: begin
                if (cnt != 5'd0) begin
                    r          = i_item.wide ? sar16_t[16:1] : {8'h00, sar8_t[8:1]};
                    o_flags.cf = i_item.wide ? sar16_t[0] : sar8_t[0];
                    o_flags.of = 1'b0;
                    o_flags.af = 1'b0;
                    use_szp    = 1'b1;
                end
            end
            ACT_INVALID: begin
                o_item.invalid_op = 1'b1;
            end
            default: begin
                o_item.invalid_op = 1'b1;
            end
        endcase

        // Derive zero, sign and parity from the result
        if (use_szp) begin
            o_flags.zf = (r == 16'h0000);
            o_flags.sf = i_item.wide ? r[15] : r[7];
            o_flags.pf = ~^r[7:0];
        end

        // Write back everything that changed the destination
        if ((i_item.action != ACT_CMP) && (i_item.action != ACT_INVALID)) begin
            if ((i_item.action < ACT_ROL) || (cnt != 5'd0)) begin
                o_item.write_back = 1'b1;
                o_item.result     = r;
            end
        end

        o_item.carry_out     = o_flags.cf;
        o_item.overflow_out  = o_flags.of;
        o_item.zero_out      = o_flags.zf;
        o_item.sign_out      = o_flags.sf;
        o_item.parity_out    = o_flags.pf;
        o_item.aux_carry_out = o_flags.af;
    end

endmodule

// ----- rtl/core/x86_immediate_alu_and_shifter.sv -----
// Top level: input register, execute logic, result register and flag register.
// A transaction moves from the input register to the result register and o_valid.
// Throughput: one per cycle unless stalled; the flag register feeds the next operation.
// The input and result registers form a two-entry pipe: an empty input register
// takes input while a result waits. Reset clears both valid bits and all six flags.
module x86_immediate_alu_and_shifter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  x86ia_pkg::t_alu_in   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output x86ia_pkg::t_alu_out  o_data
);
    import x86ia_pkg::*;

    `include "x86_immediate_alu_and_shifter_macros.svh"

    logic     r_in_valid;
    logic     n_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    logic     n_out_valid;
    t_alu_out r_out;
    t_flags   r_flags;
    t_alu_out w_alu_item;
    t_flags   w_alu_flags;
    logic     w_advance;
    logic     w_accept;

    x86ia_alu u_alu (
        .i_item  (r_in),
        .i_flags (r_flags),
        .o_item  (w_alu_item),
        .o_flags (w_alu_flags)
    );

    // Advance the input register into the result register when there is room
    always_comb begin
        w_advance   = r_in_valid && (!r_out_valid || !i_stall);
        o_stall     = r_in_valid && !w_advance;
        w_accept    = i_valid && !o_stall;
        n_in_valid  = w_accept || (r_in_valid && !w_advance);
        n_out_valid = w_advance || (r_out_valid && i_stall);
        o_valid     = r_out_valid;
        o_data      = r_out;
    end

    // Clear valid bits and flags under reset, and update them otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_flags <= w_alu_flags;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_data;
        end
        if (w_advance) begin
            r_out <= w_alu_item;
        end
    end

    `X86IA_ASSERT_NXT(a_flags_hold_on_stall, i_clk, i_rst_n, o_valid && i_stall,
        $stable(r_flags))
    `X86IA_ASSERT_IMP(a_out_flags_match, i_clk, i_rst_n, o_valid,
        (o_data.carry_out == r_flags.cf) && (o_data.overflow_out == r_flags.of) &&
        (o_data.zero_out == r_flags.zf) && (o_data.sign_out == r_flags.sf) &&
        (o_data.parity_out == r_flags.pf) && (o_data.aux_carry_out == r_flags.af))
    `X86IA_ASSERT_IMP(a_invalid_no_write, i_clk, i_rst_n, o_valid && o_data.invalid_op,
        !o_data.write_back)
    `X86IA_ASSERT_IMP(a_empty_never_stalls, i_clk, i_rst_n, !r_in_valid, !o_stall)

endmodule
